/* rtl/sst_pkg.sv */
// Shared constants for the script statement tokenizer.
package sst_pkg;

    localparam int COUNT_BITS = 16;

    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_T      = 8'h74;

    localparam logic [1:0] ROLE_NONE = 2'd0;
    localparam logic [1:0] ROLE_HEAD = 2'd1;
    localparam logic [1:0] ROLE_ARG  = 2'd2;
    localparam logic [1:0] ROLE_OPT  = 2'd3;

    localparam logic [3:0] ERR_NONE         = 4'd0;
    localparam logic [3:0] ERR_LONE_SLASH   = 4'd1;
    localparam logic [3:0] ERR_EMPTY_STMT   = 4'd2;
    localparam logic [3:0] ERR_NO_COMMA     = 4'd3;
    localparam logic [3:0] ERR_OPEN_COMMENT = 4'd4;
    localparam logic [3:0] ERR_OPEN_HEAD    = 4'd5;
    localparam logic [3:0] ERR_OPEN_ARGS    = 4'd6;
    localparam logic [3:0] ERR_OPEN_QUOTE   = 4'd7;
    localparam logic [3:0] ERR_OPEN_BRACE   = 4'd8;
    localparam logic [3:0] ERR_OPEN_CMD     = 4'd9;

endpackage

/* rtl/script_statement_tokenizer.sv */
// Byte-serial statement lexer: one result per script byte.
// The result is registered and is valid in the cycle after the input transfer.
// Throughput: 1 byte per cycle while the output is not stalled; the lexer state updates on each accepted byte.
// The result register accepts a new byte while its current result is taken.
// Reset (i_rst_n low, synchronous) resets lexer state and counters (line number to 1) and clears output valid.
// A byte with i_last high also returns all lexer state to its reset values.
module script_statement_tokenizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    output logic [1:0]  o_role,
    output logic        o_head_dot_before,
    output logic        o_stmt_start,
    output logic        o_arg_done,
    output logic        o_opt_done,
    output logic        o_stmt_done,
    output logic        o_drop_last_arg_byte,
    output logic [15:0] o_line_number,
    output logic [15:0] o_stmt_index,
    output logic [3:0]  o_error_code,
    output logic        o_script_end
);

    localparam int CW = sst_pkg::COUNT_BITS;

    typedef enum logic [3:0] {
        S_INTER     = 4'd0,
        S_CMT_LINE  = 4'd1,
        S_CMT_BLOCK = 4'd2,
        S_HEAD      = 4'd3,
        S_HEAD_SEP  = 4'd4,
        S_ARG_GAP   = 4'd5,
        S_FREE      = 4'd6,
        S_QUOTE     = 4'd7,
        S_BRACE     = 4'd8,
        S_AWAIT     = 4'd9,
        S_OPT       = 4'd10,
        S_OPT_GAP   = 4'd11,
        S_SLASH     = 4'd12
    } t_state;

    t_state          r_state, n_state;
    logic            r_esc, n_esc;
    logic            r_head_empty, n_head_empty;
    logic            r_dot, n_dot;
    logic            r_prev_nl;
    logic [CW-1:0]   r_line, n_line;
    logic [CW-1:0]   r_stmt, n_stmt;
    logic [3:0]      r_err, n_err;

    logic [7:0]      n_ob;
    logic [1:0]      n_role;
    logic            n_hdot, n_start, n_argd, n_optd, n_stmtd, n_drop;
    logic            raise;
    logic            blank, sep, in_stmt_old;
    logic [CW-1:0]   idx;
    logic [31:0]     line_ext, idx_ext;
    logic            accept;

    logic            r_o_valid;

    assign o_stall = r_o_valid & i_stall;
    assign o_valid = r_o_valid;
    assign accept  = i_valid & ~o_stall;

    assign blank = (i_in_byte inside {sst_pkg::CH_SPACE, sst_pkg::CH_LF,
                                      sst_pkg::CH_TAB, sst_pkg::CH_CR});
    assign sep   = blank | (i_in_byte inside {sst_pkg::CH_DOT, sst_pkg::CH_COMMA,
                                              sst_pkg::CH_SLASH});
    assign in_stmt_old = (r_state inside {[S_HEAD:S_OPT_GAP]});

    always_comb begin
        n_state      = r_state;
        n_esc        = r_esc;
        n_head_empty = r_head_empty;
        n_dot        = r_dot;
        n_stmt       = r_stmt;
        n_err        = r_err;
        n_ob         = 8'd0;
        n_role       = sst_pkg::ROLE_NONE;
        n_hdot       = 1'b0;
        n_start      = 1'b0;
        n_argd       = 1'b0;
        n_optd       = 1'b0;
        n_stmtd      = 1'b0;
        n_drop       = 1'b0;
        raise        = 1'b0;

        n_line = r_line;
        if (i_in_byte == sst_pkg::CH_LF && r_line != {CW{1'b1}}) begin
            n_line = r_line + 1'b1;
        end

        if (r_err == sst_pkg::ERR_NONE) begin
            if (r_esc) begin
                n_esc  = 1'b0;
                n_role = sst_pkg::ROLE_ARG;
                n_ob   = i_in_byte;
                if (r_state == S_BRACE) begin
                    if (i_in_byte == sst_pkg::CH_N) n_ob = sst_pkg::CH_LF;
                    else if (i_in_byte == sst_pkg::CH_T) n_ob = sst_pkg::CH_TAB;
                end
            end else begin
                case (r_state)
                    S_CMT_LINE: begin
                        if (i_in_byte == sst_pkg::CH_LF) n_state = S_INTER;
                    end
                    S_CMT_BLOCK: begin
                        if (i_in_byte == sst_pkg::CH_HASH) n_state = S_INTER;
                    end
                    S_SLASH: begin
                        if (i_in_byte == sst_pkg::CH_SLASH) begin
                            n_state = S_CMT_LINE;
                        end else begin
                            raise = 1'b1;
                            n_err = sst_pkg::ERR_LONE_SLASH;
                        end
                    end
                    S_HEAD, S_HEAD_SEP: begin
                        if (sep) begin
                            if (r_state == S_HEAD && !r_head_empty) n_dot = 1'b1;
                            n_state = S_HEAD_SEP;
                        end else if (i_in_byte == sst_pkg::CH_LPAREN) begin
                            n_state = S_ARG_GAP;
                        end else if (i_in_byte == sst_pkg::CH_SEMI) begin
                            n_stmtd = 1'b1;
                            n_state = S_INTER;
                        end else begin
                            n_role       = sst_pkg::ROLE_HEAD;
                            n_ob         = i_in_byte;
                            n_hdot       = r_dot;
                            n_dot        = 1'b0;
                            n_head_empty = 1'b0;
                            n_state      = S_HEAD;
                        end
                    end
                    S_ARG_GAP: begin
                        if (!blank) begin
                            if (i_in_byte == sst_pkg::CH_COMMA) begin
                                n_argd = 1'b1;
                            end else if (i_in_byte == sst_pkg::CH_RPAREN) begin
                                n_state = S_OPT_GAP;
                            end else if (i_in_byte == sst_pkg::CH_QUOTE) begin
                                n_state = S_QUOTE;
                            end else if (i_in_byte == sst_pkg::CH_LBRACE) begin
                                n_state = S_BRACE;
                            end else begin
                                n_role  = sst_pkg::ROLE_ARG;
                                n_ob    = i_in_byte;
                                n_state = S_FREE;
                            end
                        end
                    end
                    S_FREE: begin
                        if (i_in_byte == sst_pkg::CH_COMMA) begin
                            n_argd  = 1'b1;
                            n_state = S_ARG_GAP;
                        end else if (i_in_byte == sst_pkg::CH_RPAREN) begin
                            n_argd  = 1'b1;
                            n_drop  = r_prev_nl;
                            n_state = S_OPT_GAP;
                        end else begin
                            n_role = sst_pkg::ROLE_ARG;
                            n_ob   = i_in_byte;
                        end
                    end
                    S_QUOTE, S_BRACE: begin
                        if ((r_state == S_QUOTE && i_in_byte == sst_pkg::CH_QUOTE) ||
                            (r_state == S_BRACE && i_in_byte == sst_pkg::CH_RBRACE)) begin
                            n_argd  = 1'b1;
                            n_state = S_AWAIT;
                        end else if (i_in_byte == sst_pkg::CH_BSLASH && !i_last) begin
                            n_esc = 1'b1;
                        end else begin
                            n_role = sst_pkg::ROLE_ARG;
                            n_ob   = i_in_byte;
                        end
                    end
                    S_AWAIT: begin
                        if (!blank) begin
                            if (i_in_byte == sst_pkg::CH_COMMA) begin
                                n_state = S_ARG_GAP;
                            end else if (i_in_byte == sst_pkg::CH_RPAREN) begin
                                n_state = S_OPT_GAP;
                            end else begin
                                raise = 1'b1;
                                n_err = sst_pkg::ERR_NO_COMMA;
                            end
                        end
                    end
                    S_OPT: begin
                        if (blank) begin
                            n_optd  = 1'b1;
                            n_state = S_OPT_GAP;
                        end else if (i_in_byte == sst_pkg::CH_SEMI) begin
                            n_optd  = 1'b1;
                            n_stmtd = 1'b1;
                            n_state = S_INTER;
                        end else begin
                            n_role = sst_pkg::ROLE_OPT;
                            n_ob   = i_in_byte;
                        end
                    end
                    S_OPT_GAP: begin
                        if (!blank) begin
                            if (i_in_byte == sst_pkg::CH_SEMI) begin
                                n_stmtd = 1'b1;
                                n_state = S_INTER;
                            end else begin
                                n_role  = sst_pkg::ROLE_OPT;
                                n_ob    = i_in_byte;
                                n_state = S_OPT;
                            end
                        end
                    end
                    default: begin
                        if (blank) begin
                            n_state = S_INTER;
                        end else if (i_in_byte == sst_pkg::CH_SLASH) begin
                            if (i_last) begin
                                raise = 1'b1;
                                n_err = sst_pkg::ERR_LONE_SLASH;
                            end else begin
                                n_state = S_SLASH;
                            end
                        end else if (i_in_byte == sst_pkg::CH_HASH) begin
                            n_state = S_CMT_BLOCK;
                        end else if (i_in_byte == sst_pkg::CH_SEMI) begin
                            raise = 1'b1;
                            n_err = sst_pkg::ERR_EMPTY_STMT;
                        end else begin
                            n_start = 1'b1;
                            if (r_stmt != {CW{1'b1}}) n_stmt = r_stmt + 1'b1;
                            n_head_empty = 1'b1;
                            n_dot        = 1'b0;
                            if (i_in_byte != sst_pkg::CH_DOT) begin
                                n_role       = sst_pkg::ROLE_HEAD;
                                n_ob         = i_in_byte;
                                n_head_empty = 1'b0;
                            end
                            n_state = S_HEAD;
                        end
                    end
                endcase
            end

            if (raise) begin
                n_state = r_state;
                n_ob    = 8'd0;
                n_role  = sst_pkg::ROLE_NONE;
                n_hdot  = 1'b0;
                n_start = 1'b0;
                n_argd  = 1'b0;
                n_optd  = 1'b0;
                n_stmtd = 1'b0;
                n_drop  = 1'b0;
            end else if (i_last) begin
                case (n_state)
                    S_CMT_BLOCK:                n_err = sst_pkg::ERR_OPEN_COMMENT;
                    S_HEAD, S_HEAD_SEP:         n_err = sst_pkg::ERR_OPEN_HEAD;
                    S_ARG_GAP, S_FREE, S_AWAIT: n_err = sst_pkg::ERR_OPEN_ARGS;
                    S_QUOTE:                    n_err = sst_pkg::ERR_OPEN_QUOTE;
                    S_BRACE:                    n_err = sst_pkg::ERR_OPEN_BRACE;
                    S_OPT, S_OPT_GAP:           n_err = sst_pkg::ERR_OPEN_CMD;
                    default:                    n_err = r_err;
                endcase
            end
        end

        if ((n_start || in_stmt_old) && n_stmt != '0) idx = n_stmt - 1'b1;
        else idx = n_stmt;

        line_ext = 32'(n_line);
        idx_ext  = 32'(idx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_INTER;
            r_esc        <= 1'b0;
            r_head_empty <= 1'b1;
            r_dot        <= 1'b0;
            r_prev_nl    <= 1'b0;
            r_line       <= CW'(1);
            r_stmt       <= '0;
            r_err        <= sst_pkg::ERR_NONE;
            r_o_valid    <= 1'b0;
        end else begin
            if (accept) begin
                r_o_valid <= 1'b1;
                if (i_last) begin
                    r_state      <= S_INTER;
                    r_esc        <= 1'b0;
                    r_head_empty <= 1'b1;
                    r_dot        <= 1'b0;
                    r_prev_nl    <= 1'b0;
                    r_line       <= CW'(1);
                    r_stmt       <= '0;
                    r_err        <= sst_pkg::ERR_NONE;
                end else begin
                    r_state      <= n_state;
                    r_esc        <= n_esc;
                    r_head_empty <= n_head_empty;
                    r_dot        <= n_dot;
                    r_prev_nl    <= (i_in_byte == sst_pkg::CH_LF);
                    r_line       <= n_line;
                    r_stmt       <= n_stmt;
                    r_err        <= n_err;
                end
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            o_out_byte           <= n_ob;
            o_role               <= n_role;
            o_head_dot_before    <= n_hdot;
            o_stmt_start         <= n_start;
            o_arg_done           <= n_argd;
            o_opt_done           <= n_optd;
            o_stmt_done          <= n_stmtd;
            o_drop_last_arg_byte <= n_drop;
            o_line_number        <= (line_ext > 32'd65535) ? 16'hFFFF : line_ext[15:0];
            o_stmt_index         <= (idx_ext > 32'd65535) ? 16'hFFFF : idx_ext[15:0];
            o_error_code         <= n_err;
            o_script_end         <= i_last;
        end
    end

endmodule

/* tb/script_statement_tokenizer_tb.sv */
// Self-checking testbench for the script statement tokenizer: directed table, random scripts.
`timescale 1ns / 100ps

module script_statement_tokenizer_tb;

    localparam longint unsigned CNT_MAX     = (64'd1 << sst_pkg::COUNT_BITS) - 64'd1;
    localparam int              STUCK_LIMIT = 2000;
    localparam int              HOLD_CYCLES = 80;

    typedef enum logic [3:0] {
        LX_INTER, LX_LINE_CMT, LX_BLOCK_CMT, LX_HEAD, LX_HEAD_SEP, LX_ARG_GAP, LX_FREE,
        LX_QUOTE, LX_BRACE, LX_AWAIT, LX_OPT, LX_OPT_GAP, LX_SLASH
    } t_lex;

    typedef enum {
        PK_HEAD, PK_FREE_HEAD, PK_FREE, PK_QUOTE, PK_BRACE, PK_OPT, PK_BLOCK, PK_LINE
    } t_pick;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [1:0]  role;
        logic        hdot;
        logic        start;
        logic        argd;
        logic        optd;
        logic        stmtd;
        logic        drop;
        logic [15:0] line_no;
        logic [15:0] idx;
        logic [3:0]  err;
        logic        last_mark;
    } t_tok_res;

    typedef struct {
        logic [7:0] b;
        bit         lst;
        bit         typed;
        logic [1:0] role;
        logic [3:0] err;
    } t_dir_row;

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        i_valid   = 1'b0;
    logic [7:0]  i_in_byte = 8'h00;
    logic        i_last    = 1'b0;
    logic        i_stall   = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [7:0]  o_out_byte;
    logic [1:0]  o_role;
    logic        o_head_dot_before;
    logic        o_stmt_start;
    logic        o_arg_done;
    logic        o_opt_done;
    logic        o_stmt_done;
    logic        o_drop_last_arg_byte;
    logic [15:0] o_line_number;
    logic [15:0] o_stmt_index;
    logic [3:0]  o_error_code;
    logic        o_script_end;

    // predictor state
    t_lex              lx_state;
    bit                esc_pend;
    bit                head_empty;
    bit                dot_pend;
    bit                prev_nl;
    longint unsigned   line_cnt;
    longint unsigned   stmt_cnt;
    logic [3:0]        sticky_err;

    t_tok_res   tok_exp_q[$];
    t_tok_res   got_tok;
    t_tok_res   want_tok;
    t_dir_row   dir_tab[$];
    logic [7:0] scr_q[$];
    int         mism_cnt = 0;
    int         sent_cnt = 0;
    bit         calm     = 1'b0;
    bit         hold_req = 1'b0;

    script_statement_tokenizer u_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_stall              (o_stall),
        .i_in_byte            (i_in_byte),
        .i_last               (i_last),
        .o_valid              (o_valid),
        .i_stall              (i_stall),
        .o_out_byte           (o_out_byte),
        .o_role               (o_role),
        .o_head_dot_before    (o_head_dot_before),
        .o_stmt_start         (o_stmt_start),
        .o_arg_done           (o_arg_done),
        .o_opt_done           (o_opt_done),
        .o_stmt_done          (o_stmt_done),
        .o_drop_last_arg_byte (o_drop_last_arg_byte),
        .o_line_number        (o_line_number),
        .o_stmt_index         (o_stmt_index),
        .o_error_code         (o_error_code),
        .o_script_end         (o_script_end)
    );

    always #5 i_clk = ~i_clk;

    function automatic bit is_blank(input logic [7:0] c);
        return c == sst_pkg::CH_SPACE || c == sst_pkg::CH_LF || c == sst_pkg::CH_TAB ||
               c == sst_pkg::CH_CR;
    endfunction

    function automatic bit is_sep(input logic [7:0] c);
        return is_blank(c) || c == sst_pkg::CH_DOT || c == sst_pkg::CH_COMMA ||
               c == sst_pkg::CH_SLASH;
    endfunction

    function automatic void pred_reset();
        lx_state   = LX_INTER;
        esc_pend   = 1'b0;
        head_empty = 1'b1;
        dot_pend   = 1'b0;
        prev_nl    = 1'b0;
        line_cnt   = 1;
        stmt_cnt   = 0;
        sticky_err = sst_pkg::ERR_NONE;
    endfunction

    function automatic t_tok_res predict_token(input logic [7:0] c, input bit lst);
        t_tok_res        r;
        t_lex            s;
        t_lex            old;
        longint unsigned idx;
        r   = '0;
        old = lx_state;
        s   = lx_state;
        if (c == sst_pkg::CH_LF && line_cnt < CNT_MAX) line_cnt++;
        if (sticky_err == sst_pkg::ERR_NONE) begin
            if (esc_pend) begin
                esc_pend   = 1'b0;
                r.role     = sst_pkg::ROLE_ARG;
                r.out_byte = c;
                if (s == LX_BRACE) begin
                    if (c == sst_pkg::CH_N) r.out_byte = sst_pkg::CH_LF;
                    else if (c == sst_pkg::CH_T) r.out_byte = sst_pkg::CH_TAB;
                end
            end else begin
                case (s)
                    LX_LINE_CMT: if (c == sst_pkg::CH_LF) s = LX_INTER;
                    LX_BLOCK_CMT: if (c == sst_pkg::CH_HASH) s = LX_INTER;
                    LX_SLASH: begin
                        if (c == sst_pkg::CH_SLASH) s = LX_LINE_CMT;
                        else sticky_err = sst_pkg::ERR_LONE_SLASH;
                    end
                    LX_HEAD, LX_HEAD_SEP: begin
                        if (is_sep(c)) begin
                            if (s == LX_HEAD && !head_empty) dot_pend = 1'b1;
                            s = LX_HEAD_SEP;
                        end else if (c == sst_pkg::CH_LPAREN) begin
                            s = LX_ARG_GAP;
                        end else if (c == sst_pkg::CH_SEMI) begin
                            r.stmtd = 1'b1;
                            s = LX_INTER;
                        end else begin
                            r.role     = sst_pkg::ROLE_HEAD;
                            r.out_byte = c;
                            r.hdot     = dot_pend;
                            dot_pend   = 1'b0;
                            head_empty = 1'b0;
                            s = LX_HEAD;
                        end
                    end
                    LX_ARG_GAP: begin
                        if (!is_blank(c)) begin
                            if (c == sst_pkg::CH_COMMA) r.argd = 1'b1;
                            else if (c == sst_pkg::CH_RPAREN) s = LX_OPT_GAP;
                            else if (c == sst_pkg::CH_QUOTE) s = LX_QUOTE;
                            else if (c == sst_pkg::CH_LBRACE) s = LX_BRACE;
                            else begin
                                r.role     = sst_pkg::ROLE_ARG;
                                r.out_byte = c;
                                s = LX_FREE;
                            end
                        end
                    end
                    LX_FREE: begin
                        if (c == sst_pkg::CH_COMMA) begin
                            r.argd = 1'b1;
                            s = LX_ARG_GAP;
                        end else if (c == sst_pkg::CH_RPAREN) begin
                            r.argd = 1'b1;
                            r.drop = prev_nl;
                            s = LX_OPT_GAP;
                        end else begin
                            r.role     = sst_pkg::ROLE_ARG;
                            r.out_byte = c;
                        end
                    end
                    LX_QUOTE, LX_BRACE: begin
                        if ((s == LX_QUOTE && c == sst_pkg::CH_QUOTE) ||
                            (s == LX_BRACE && c == sst_pkg::CH_RBRACE)) begin
                            r.argd = 1'b1;
                            s = LX_AWAIT;
                        end else if (c == sst_pkg::CH_BSLASH && !lst) begin
                            esc_pend = 1'b1;
                        end else begin
                            r.role     = sst_pkg::ROLE_ARG;
                            r.out_byte = c;
                        end
                    end
                    LX_AWAIT: begin
                        if (!is_blank(c)) begin
                            if (c == sst_pkg::CH_COMMA) s = LX_ARG_GAP;
                            else if (c == sst_pkg::CH_RPAREN) s = LX_OPT_GAP;
                            else sticky_err = sst_pkg::ERR_NO_COMMA;
                        end
                    end
                    LX_OPT: begin
                        if (is_blank(c)) begin
                            r.optd = 1'b1;
                            s = LX_OPT_GAP;
                        end else if (c == sst_pkg::CH_SEMI) begin
                            r.optd  = 1'b1;
                            r.stmtd = 1'b1;
                            s = LX_INTER;
                        end else begin
                            r.role     = sst_pkg::ROLE_OPT;
                            r.out_byte = c;
                        end
                    end
                    LX_OPT_GAP: begin
                        if (!is_blank(c)) begin
                            if (c == sst_pkg::CH_SEMI) begin
                                r.stmtd = 1'b1;
                                s = LX_INTER;
                            end else begin
                                r.role     = sst_pkg::ROLE_OPT;
                                r.out_byte = c;
                                s = LX_OPT;
                            end
                        end
                    end
                    default: begin
                        if (is_blank(c)) begin
                            s = LX_INTER;
                        end else if (c == sst_pkg::CH_SLASH) begin
                            if (lst) sticky_err = sst_pkg::ERR_LONE_SLASH;
                            else s = LX_SLASH;
                        end else if (c == sst_pkg::CH_HASH) begin
                            s = LX_BLOCK_CMT;
                        end else if (c == sst_pkg::CH_SEMI) begin
                            sticky_err = sst_pkg::ERR_EMPTY_STMT;
                        end else begin
                            r.start = 1'b1;
                            if (stmt_cnt < CNT_MAX) stmt_cnt++;
                            head_empty = 1'b1;
                            dot_pend   = 1'b0;
                            if (c != sst_pkg::CH_DOT) begin
                                r.role     = sst_pkg::ROLE_HEAD;
                                r.out_byte = c;
                                head_empty = 1'b0;
                            end
                            s = LX_HEAD;
                        end
                    end
                endcase
            end
            if (sticky_err != sst_pkg::ERR_NONE) begin
                r = '0;
            end else begin
                lx_state = s;
                if (lst) begin
                    case (s)
                        LX_BLOCK_CMT:                  sticky_err = sst_pkg::ERR_OPEN_COMMENT;
                        LX_HEAD, LX_HEAD_SEP:          sticky_err = sst_pkg::ERR_OPEN_HEAD;
                        LX_ARG_GAP, LX_FREE, LX_AWAIT: sticky_err = sst_pkg::ERR_OPEN_ARGS;
                        LX_QUOTE:                      sticky_err = sst_pkg::ERR_OPEN_QUOTE;
                        LX_BRACE:                      sticky_err = sst_pkg::ERR_OPEN_BRACE;
                        LX_OPT, LX_OPT_GAP:            sticky_err = sst_pkg::ERR_OPEN_CMD;
                        default: ;
                    endcase
                end
            end
        end
        if ((r.start || (old >= LX_HEAD && old <= LX_OPT_GAP)) && stmt_cnt > 0)
            idx = stmt_cnt - 1;
        else
            idx = stmt_cnt;
        r.line_no   = (line_cnt > 65535) ? 16'hFFFF : 16'(line_cnt);
        r.idx       = (idx > 65535) ? 16'hFFFF : 16'(idx);
        r.err       = sticky_err;
        r.last_mark = lst;
        prev_nl = (c == sst_pkg::CH_LF);
        if (lst) pred_reset();
        return r;
    endfunction

    function automatic string fmt_tok(input t_tok_res t);
        return $sformatf({"byte=%h role=%0d hdot=%b start=%b argd=%b optd=%b stmtd=%b ",
                          "drop=%b line=%0d idx=%0d err=%0d end=%b"},
                         t.out_byte, t.role, t.hdot, t.start, t.argd, t.optd, t.stmtd,
                         t.drop, t.line_no, t.idx, t.err, t.last_mark);
    endfunction

    function automatic logic [7:0] pick_byte(input t_pick k);
        logic [7:0] b;
        bit         bad;
        do begin
            if ($urandom_range(1, 0) != 0) b = 8'($urandom_range(255, 0));
            else b = 8'($urandom_range(8'h7E, 8'h21));
            case (k)
                PK_HEAD:      bad = is_sep(b) || b == sst_pkg::CH_LPAREN ||
                                    b == sst_pkg::CH_SEMI || b == sst_pkg::CH_HASH;
                PK_FREE_HEAD: bad = is_blank(b) || b == sst_pkg::CH_COMMA ||
                                    b == sst_pkg::CH_RPAREN || b == sst_pkg::CH_QUOTE ||
                                    b == sst_pkg::CH_LBRACE;
                PK_FREE:      bad = b == sst_pkg::CH_COMMA || b == sst_pkg::CH_RPAREN;
                PK_QUOTE:     bad = b == sst_pkg::CH_QUOTE || b == sst_pkg::CH_BSLASH;
                PK_BRACE:     bad = b == sst_pkg::CH_RBRACE || b == sst_pkg::CH_BSLASH;
                PK_OPT:       bad = is_blank(b) || b == sst_pkg::CH_SEMI;
                PK_BLOCK:     bad = b == sst_pkg::CH_HASH;
                default:      bad = b == sst_pkg::CH_LF;
            endcase
        end while (bad);
        return b;
    endfunction

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(3, 0))
            0:       return sst_pkg::CH_SPACE;
            1:       return sst_pkg::CH_LF;
            2:       return sst_pkg::CH_TAB;
            default: return sst_pkg::CH_CR;
        endcase
    endfunction

    function automatic logic [7:0] pick_sep();
        case ($urandom_range(6, 0))
            0:       return sst_pkg::CH_DOT;
            1:       return sst_pkg::CH_COMMA;
            2:       return sst_pkg::CH_SLASH;
            default: return pick_blank();
        endcase
    endfunction

    task automatic add_byte(input logic [7:0] b);
        scr_q.insert(scr_q.size(), b);
    endtask

    task automatic add_blanks(input int lo, input int hi);
        repeat ($urandom_range(hi, lo)) add_byte(pick_blank());
    endtask

    task automatic add_row(input logic [7:0] b, input bit lst, input bit typed,
                           input logic [1:0] role, input logic [3:0] err);
        t_dir_row row;
        row.b     = b;
        row.lst   = lst;
        row.typed = typed;
        row.role  = role;
        row.err   = err;
        dir_tab.insert(dir_tab.size(), row);
    endtask

    // Offers one byte, holds it until the transfer, then records what it should produce.
    task automatic send_byte(input logic [7:0] b, input bit lst, input bit typed,
                             input logic [1:0] role, input logic [3:0] err);
        t_tok_res want;
        if (!calm && $urandom_range(5, 0) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(12, 1)) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_in_byte <= b;
        i_last    <= lst;
        do @(posedge i_clk); while (o_stall);
        want = predict_token(b, lst);
        if (typed) begin
            want.role = role;
            want.err  = err;
        end
        tok_exp_q.insert(tok_exp_q.size(), want);
        sent_cnt++;
    endtask

    task automatic gen_stmt();
        int lead;
        int nargs;
        int kind;
        lead = $urandom_range(7, 0);
        if (lead == 0) add_byte(sst_pkg::CH_DOT);
        else if (lead == 1) add_byte(sst_pkg::CH_COMMA);
        for (int s = 0; s < 3; s++) begin
            if (s == 0 || $urandom_range(1, 0) != 0) begin
                if (s > 0) repeat ($urandom_range(2, 1)) add_byte(pick_sep());
                repeat ($urandom_range(4, 1)) add_byte(pick_byte(PK_HEAD));
            end
        end
        if ($urandom_range(3, 0) == 0) repeat ($urandom_range(2, 1)) add_byte(pick_sep());
        if ($urandom_range(2, 0) != 0) begin
            add_byte(sst_pkg::CH_LPAREN);
            nargs = $urandom_range(3, 0);
            for (int a = 0; a < nargs; a++) begin
                if (a > 0) add_byte(sst_pkg::CH_COMMA);
                if ($urandom_range(2, 0) == 0) add_blanks(1, 2);
                kind = $urandom_range(2, 0);
                if (kind == 0) begin
                    add_byte(pick_byte(PK_FREE_HEAD));
                    repeat ($urandom_range(4, 0)) add_byte(pick_byte(PK_FREE));
                    if (a == nargs - 1 && $urandom_range(2, 0) == 0) add_byte(sst_pkg::CH_LF);
                end else begin
                    add_byte(kind == 1 ? sst_pkg::CH_QUOTE : sst_pkg::CH_LBRACE);
                    repeat ($urandom_range(4, 0)) begin
                        if ($urandom_range(3, 0) == 0) begin
                            add_byte(sst_pkg::CH_BSLASH);
                            if (kind == 2 && $urandom_range(1, 0) != 0)
                                add_byte($urandom_range(1, 0) != 0 ? sst_pkg::CH_N
                                                                   : sst_pkg::CH_T);
                            else
                                add_byte(8'($urandom_range(255, 0)));
                        end else begin
                            add_byte(pick_byte(kind == 1 ? PK_QUOTE : PK_BRACE));
                        end
                    end
                    add_byte(kind == 1 ? sst_pkg::CH_QUOTE : sst_pkg::CH_RBRACE);
                    if ($urandom_range(2, 0) == 0) add_blanks(1, 2);
                end
            end
            add_byte(sst_pkg::CH_RPAREN);
            repeat ($urandom_range(2, 0)) begin
                add_blanks(1, 2);
                repeat ($urandom_range(4, 1)) add_byte(pick_byte(PK_OPT));
            end
        end
        if ($urandom_range(3, 0) == 0) add_blanks(1, 2);
        add_byte(sst_pkg::CH_SEMI);
    endtask

    task automatic gen_gap();
        repeat ($urandom_range(2, 0)) begin
            case ($urandom_range(2, 0))
                0: add_blanks(1, 3);
                1: begin
                    add_byte(sst_pkg::CH_HASH);
                    repeat ($urandom_range(5, 0)) add_byte(pick_byte(PK_BLOCK));
                    add_byte(sst_pkg::CH_HASH);
                end
                default: begin
                    add_byte(sst_pkg::CH_SLASH);
                    add_byte(sst_pkg::CH_SLASH);
                    repeat ($urandom_range(5, 0)) add_byte(pick_byte(PK_LINE));
                    add_byte(sst_pkg::CH_LF);
                end
            endcase
        end
    endtask

    // Mostly well-formed scripts; some are noise, truncated or have one byte corrupted.
    task automatic gen_script();
        int kind;
        int pos;
        scr_q.delete();
        kind = $urandom_range(9, 0);
        if (kind == 0) begin
            repeat ($urandom_range(12, 2)) add_byte(8'($urandom_range(255, 0)));
        end else begin
            gen_gap();
            repeat ($urandom_range(3, 1)) begin
                gen_stmt();
                gen_gap();
            end
            pos = $urandom_range(scr_q.size() - 1, 0);
            if (kind == 1) scr_q = scr_q[0:pos];
            else if (kind == 2) scr_q[pos] = 8'($urandom_range(255, 0));
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            got_tok = {o_out_byte, o_role, o_head_dot_before, o_stmt_start, o_arg_done,
                       o_opt_done, o_stmt_done, o_drop_last_arg_byte, o_line_number,
                       o_stmt_index, o_error_code, o_script_end};
            if (tok_exp_q.size() == 0) begin
                if (mism_cnt < 10) $display("%0t: transfer with none expected: %s",
                                            $time, fmt_tok(got_tok));
                mism_cnt++;
            end else begin
                want_tok = tok_exp_q.pop_front();
                if (got_tok !== want_tok) begin
                    if (mism_cnt < 10) begin
                        $display("%0t: mismatch exp %s", $time, fmt_tok(want_tok));
                        $display("%0t:          got %s", $time, fmt_tok(got_tok));
                    end
                    mism_cnt++;
                end
            end
        end
    end

    // output stall: random bursts, plus a long hold on request
    initial begin : stall_gen
        int hold_cnt;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_stall <= 1'b1;
                hold_cnt = 0;
                while (hold_cnt < HOLD_CYCLES) begin
                    @(posedge i_clk);
                    hold_cnt++;
                end
                i_stall <= 1'b0;
            end else if (!calm && $urandom_range(7, 0) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(12, 1)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    initial begin : watchdog
        int stuck;
        stuck = 0;
        wait (i_rst_n);
        while (stuck < STUCK_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) stuck = 0;
            else stuck++;
        end
        $display("** script_statement_tokenizer: FAILED **");
        $finish;
    end

    initial begin : stimulus
        int scr_n;
        pred_reset();
        // extremes, head separators, newline before ')', options
        add_row(8'h00,              1'b0, 1'b1, sst_pkg::ROLE_HEAD, sst_pkg::ERR_NONE);
        add_row(8'hFF,              1'b0, 1'b0, sst_pkg::ROLE_NONE, sst_pkg::ERR_NONE);
        add_row(sst_pkg::CH_DOT,    1'b0, 1'b0, sst_pkg::ROLE_NONE, sst_pkg::ERR_NONE);
        add_row("x",                1'b0, 1'b0, sst_pkg::ROLE_NONE, sst_pkg::ERR_NONE);
        add_row(sst_pkg::CH_LPAREN, 1'b0, 1'b0, sst_pkg::ROLE_NONE, sst_pkg::ERR_NONE);
        add_row("a",                1'b0, 1'b0, sst_pkg::ROLE_NONE, sst_pkg::ERR_NONE);
        add_row(sst_pkg::CH_LF,     1'b0, 1'b0, sst_pkg::ROLE_NONE, sst_pkg::ERR_NONE);
        add_row(sst_pkg::CH_RPAREN, 1'b0, 1'b0, sst_pkg::ROLE_NONE, sst_pkg::ERR_NONE);
        add_row("-",                1'b0, 1'b0, sst_pkg::ROLE_NONE, sst_pkg::ERR_NONE);
        add_row(sst_pkg::CH_SEMI,   1'b1, 1'b1, sst_pkg::ROLE_NONE, sst_pkg::ERR_NONE);
        // lone slash, then sticky error through the last byte
        add_row(sst_pkg::CH_SLASH,  1'b0, 1'b0, sst_pkg::ROLE_NONE, sst_pkg::ERR_NONE);
        add_row("x",                1'b0, 1'b1, sst_pkg::ROLE_NONE, sst_pkg::ERR_LONE_SLASH);
        add_row(sst_pkg::CH_SLASH,  1'b1, 1'b1, sst_pkg::ROLE_NONE, sst_pkg::ERR_LONE_SLASH);
        // comma as first head byte, escape on the last byte
        add_row(sst_pkg::CH_COMMA,  1'b0, 1'b1, sst_pkg::ROLE_HEAD, sst_pkg::ERR_NONE);
        add_row(sst_pkg::CH_LPAREN, 1'b0, 1'b0, sst_pkg::ROLE_NONE, sst_pkg::ERR_NONE);
        add_row(sst_pkg::CH_QUOTE,  1'b0, 1'b0, sst_pkg::ROLE_NONE, sst_pkg::ERR_NONE);
        add_row(sst_pkg::CH_BSLASH, 1'b1, 1'b1, sst_pkg::ROLE_ARG,  sst_pkg::ERR_OPEN_QUOTE);
        // leading dot, empty statement, block comment still open at the last byte
        add_row(sst_pkg::CH_DOT,    1'b0, 1'b1, sst_pkg::ROLE_NONE, sst_pkg::ERR_NONE);
        add_row(sst_pkg::CH_SEMI,   1'b1, 1'b0, sst_pkg::ROLE_NONE, sst_pkg::ERR_NONE);
        add_row(sst_pkg::CH_SEMI,   1'b1, 1'b1, sst_pkg::ROLE_NONE, sst_pkg::ERR_EMPTY_STMT);
        add_row(sst_pkg::CH_HASH,   1'b1, 1'b1, sst_pkg::ROLE_NONE, sst_pkg::ERR_OPEN_COMMENT);
        // missing comma after a braced argument
        add_row("h",                1'b0, 1'b0, sst_pkg::ROLE_NONE, sst_pkg::ERR_NONE);
        add_row(sst_pkg::CH_LPAREN, 1'b0, 1'b0, sst_pkg::ROLE_NONE, sst_pkg::ERR_NONE);
        add_row(sst_pkg::CH_LBRACE, 1'b0, 1'b0, sst_pkg::ROLE_NONE, sst_pkg::ERR_NONE);
        add_row(sst_pkg::CH_RBRACE, 1'b0, 1'b0, sst_pkg::ROLE_NONE, sst_pkg::ERR_NONE);
        add_row("x",                1'b0, 1'b1, sst_pkg::ROLE_NONE, sst_pkg::ERR_NO_COMMA);
        add_row("y",                1'b1, 1'b1, sst_pkg::ROLE_NONE, sst_pkg::ERR_NO_COMMA);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[i])
            send_byte(dir_tab[i].b, dir_tab[i].lst, dir_tab[i].typed, dir_tab[i].role,
                      dir_tab[i].err);

        scr_n = 0;
        while (sent_cnt < 670) begin
            calm = (sent_cnt >= 580) || ($urandom_range(4, 0) == 0);
            if (scr_n % 37 == 5 && sent_cnt < 580) hold_req = 1'b1;
            if (scr_n % 29 == 3 && sent_cnt < 580) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
                while (tok_exp_q.size() != 0) @(posedge i_clk);
            end
            gen_script();
            foreach (scr_q[i])
                send_byte(scr_q[i], i == scr_q.size() - 1, 1'b0, sst_pkg::ROLE_NONE,
                          sst_pkg::ERR_NONE);
            scr_n++;
        end

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (tok_exp_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (mism_cnt == 0)
            $display("** script_statement_tokenizer: PASSED **");
        else
            $display("** script_statement_tokenizer: FAILED **");
        $finish;
    end

endmodule
